>>> hw/rtl/gaussian_grid_splatter_assert.svh
// assertion macros for the checker file of the grid splatter
// expects a clock named clk and an active high reset named rst in scope
`ifndef GAUSSIAN_GRID_SPLATTER_ASSERT_SVH
`define GAUSSIAN_GRID_SPLATTER_ASSERT_SVH

// same-cycle implication
`define GGS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/ggs_pkg.sv
// shared types and constants of the grid splatter
// used by ggs_ctrl, ggs_datapath and the top level
package ggs_pkg;

  localparam int OFF_W     = 6;   // window offsets, covers reach up to 31
  localparam int DIM_W     = 11;  // grid extent, covers up to 2047 cells
  localparam int DRAIN_CYC = 8;   // cell pipeline depth up to the write
  localparam int IN_W      = 88;
  localparam int OUT_W     = 104;

  localparam logic OP_SPLAT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_REACH       = 2'd2;
  localparam logic [1:0] REG_INV_CUTOFF  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } ggs_state_t;

  typedef struct packed {
    logic             load;        // latch the input beat
    logic             issue;       // push one window cell into the pipe
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic             clear_step;  // zero one memory entry
    logic             rd;          // read the requested cell
    logic             load_out;    // move read data to the output register
  } ggs_cmd_t;

  typedef struct packed {
    logic             clear_last;
    logic             out_full;
    logic             is_read;
    logic [OFF_W-1:0] reach;
  } ggs_stat_t;

endpackage

>>> hw/rtl/ggs_ctrl.sv
// controller of the grid splatter: clears the memory after reset, walks the splat window and sequences reads
// depends on ggs_pkg
module ggs_ctrl import ggs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ggs_stat_t stat,
  output ggs_cmd_t  cmd
);

  ggs_state_t       state, state_next;
  logic [OFF_W-1:0] off_x, off_x_next;
  logic [OFF_W-1:0] off_y, off_y_next;
  logic [2:0]       drain, drain_next;
  logic [OFF_W-1:0] span;

  assign span = OFF_W'({stat.reach, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      off_x <= '0;
      off_y <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      off_x <= off_x_next;
      off_y <= off_y_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    off_x_next = off_x;
    off_y_next = off_y;
    drain_next = drain;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.off_x  = off_x;
    cmd.off_y  = off_y;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        off_x_next = '0;
        off_y_next = '0;
        if (in_valid) state_next = stat.is_read ? ST_READ : ST_SPLAT;
      end
      ST_SPLAT: begin
        cmd.issue = 1'b1;
        if (off_y == span) begin
          off_y_next = '0;
          if (off_x == span) begin
            drain_next = '0;
            state_next = ST_DRAIN;
          end else begin
            off_x_next = off_x + 1'b1;
          end
        end else begin
          off_y_next = off_y + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_next = drain + 1'b1;
        if (drain == 3'(DRAIN_CYC - 1)) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (!stat.out_full) begin
          cmd.rd = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd.load_out = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/ggs_datapath.sv
// datapath of the grid splatter: config registers, cell pipeline, weight rom,
// accumulator memory and output register; depends on ggs_pkg
module ggs_datapath import ggs_pkg::*; #(
  parameter int GRID_W           = 256,
  parameter int GRID_H           = 256,
  parameter int MAX_REACH        = 15,
  parameter int WEIGHT_ROM_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [IN_W-1:0]  in_data,
  input  logic             in_user,
  input  ggs_cmd_t         cmd,
  output ggs_stat_t        stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(WEIGHT_ROM_DEPTH);

  typedef logic [15:0] rom_t [WEIGHT_ROM_DEPTH];

  // exp(-i/16) in q0.16, stepped by a q0.32 factor
  function automatic rom_t build_rom();
    rom_t        t;
    logic [95:0] e;
    logic [95:0] q;
    e = 96'd1 << 32;
    for (int i = 0; i < WEIGHT_ROM_DEPTH; i++) begin
      q = (e + 96'd32768) >> 16;
      t[i] = (q > 96'd65535) ? 16'hFFFF : q[15:0];
      e = (e * 96'd4034748382 + (96'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam rom_t WROM = build_rom();

  // config
  logic [8:0]  grid_width, grid_height;
  logic [3:0]  reach_cells;
  logic [15:0] inv_cutoff_sq;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [OFF_W-1:0] r_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= 9'd256;
      grid_height   <= 9'd256;
      reach_cells   <= 4'd10;
      inv_cutoff_sq <= 16'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width    <= cfg_data[8:0];
        REG_GRID_HEIGHT: grid_height   <= cfg_data[8:0];
        REG_REACH:       reach_cells   <= cfg_data[3:0];
        REG_INV_CUTOFF:  inv_cutoff_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = ({2'b0, grid_width} > DIM_W'(GRID_W)) ? DIM_W'(GRID_W) : {2'b0, grid_width};
  assign h_eff = ({2'b0, grid_height} > DIM_W'(GRID_H)) ? DIM_W'(GRID_H)
                                                        : {2'b0, grid_height};
  assign r_eff = ({2'b0, reach_cells} > OFF_W'(MAX_REACH)) ? OFF_W'(MAX_REACH)
                                                           : {2'b0, reach_cells};

  // input beat fields
  logic signed [17:0] in_px, in_py;
  logic [7:0]         in_cx, in_cy;
  logic signed [18:0] px19, py19, mag_x, mag_y;
  logic signed [11:0] cell_px, cell_py;

  assign in_px = in_data[17:0];
  assign in_py = in_data[35:18];
  assign in_cx = in_data[75:68];
  assign in_cy = in_data[83:76];
  assign px19  = 19'(in_px);
  assign py19  = 19'(in_py);
  assign mag_x = (px19 < 0) ? -px19 : px19;
  assign mag_y = (py19 < 0) ? -py19 : py19;
  // cell of the point, rounded toward zero
  assign cell_px = (px19 < 0) ? -12'(mag_x >>> 8) : 12'(mag_x >>> 8);
  assign cell_py = (py19 < 0) ? -12'(mag_y >>> 8) : 12'(mag_y >>> 8);

  logic signed [17:0] px, py;
  logic signed [31:0] val;
  logic signed [11:0] base_x, base_y;
  logic               rd_in;
  logic [AW-1:0]      rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px      <= in_px;
      py      <= in_py;
      val     <= in_data[67:36];
      base_x  <= cell_px - $signed({6'b0, r_eff});
      base_y  <= cell_py - $signed({6'b0, r_eff});
      rd_in   <= ({3'b0, in_cx} < w_eff) && ({3'b0, in_cy} < h_eff);
      rd_addr <= AW'(32'(in_cy) * GRID_W + 32'(in_cx));
    end
  end

  // cell pipeline
  logic               v1, v2, v3, v4, v5, v6, v7;
  logic signed [11:0] x1, y1;
  logic signed [21:0] dx2, dy2;
  logic signed [43:0] sqx3, sqy3;
  logic [44:0]        d24;
  logic [60:0]        scaled;
  logic [RW-1:0]      idx5;
  logic               ok5;
  logic [15:0]        wt6, wt7;
  logic signed [48:0] prod7;
  logic [AW-1:0]      addr2, addr3, addr4, addr5, addr6, addr7;
  logic               inside1;

  assign inside1 = (x1 >= 0) && (y1 >= 0) && (x1 < $signed({1'b0, w_eff}))
                && (y1 < $signed({1'b0, h_eff}));
  assign scaled  = d24 * inv_cutoff_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1 && inside1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    x1    <= base_x + $signed({6'b0, cmd.off_x});
    y1    <= base_y + $signed({6'b0, cmd.off_y});
    dx2   <= 22'(px) - ((22'(x1) <<< 8) + 22'sd128);
    dy2   <= 22'(py) - ((22'(y1) <<< 8) + 22'sd128);
    addr2 <= AW'(32'(y1) * GRID_W + 32'(x1));
    sqx3  <= dx2 * dx2;
    sqy3  <= dy2 * dy2;
    addr3 <= addr2;
    d24   <= {1'b0, $unsigned(sqx3)} + {1'b0, $unsigned(sqy3)};
    addr4 <= addr3;
    ok5   <= scaled[60:28] < 33'(WEIGHT_ROM_DEPTH);
    idx5  <= scaled[28 +: RW];
    addr5 <= addr4;
    wt6   <= ok5 ? WROM[idx5] : 16'd0;
    addr6 <= addr5;
    prod7 <= val * $signed({1'b0, wt6});
    wt7   <= wt6;
    addr7 <= addr6;
  end

  // accumulator memory, weight total above the sum
  logic [OUT_W-1:0] mem [DEPTH];
  logic [OUT_W-1:0] rdata;
  logic [AW-1:0]    clr_addr;
  logic signed [64:0] sum65;
  logic [40:0]        wt41;
  logic [63:0]        sum_new;
  logic [39:0]        wt_new;

  assign sum65   = {rdata[63], rdata[63:0]} + 65'(prod7);
  assign sum_new = (sum65[64] != sum65[63]) ? {sum65[64], {63{~sum65[64]}}} : sum65[63:0];
  assign wt41    = {1'b0, rdata[103:64]} + {25'b0, wt7};
  assign wt_new  = wt41[40] ? '1 : wt41[39:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr] <= '0;
    end else if (v7) begin
      mem[addr7] <= {wt_new, sum_new};
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[cmd.rd ? rd_addr : addr6];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= rd_in ? rdata : '0;
  end

  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.out_full   = out_valid;
  assign stat.is_read    = (in_user == OP_READ);
  assign stat.reach      = r_eff;

endmodule

>>> hw/rtl/gaussian_grid_splatter.sv
// Gaussian grid splatter: accumulates gaussian-weighted points into a grid of
// sum and weight-total pairs and reads single cells back. A splat beat walks a
// (2r+1)^2 cell window, r the effective reach: the accumulator memory, with one
// read and one write port, does one read-modify-write per window cell inside
// the grid through the cell pipeline, which drains before the next beat. A read
// beat goes through the same memory read port. After reset the block zeroes
// all GRID_W*GRID_H entries (65536 by default), one entry a cycle, and takes no
// beat until then; config writes are always taken and must only be issued while
// the block is idle.
// depends on ggs_pkg, ggs_ctrl, ggs_datapath
module gaussian_grid_splatter import ggs_pkg::*; #(
  parameter int GRID_W           = 256,
  parameter int GRID_H           = 256,
  parameter int MAX_REACH        = 15,
  parameter int WEIGHT_ROM_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  // config write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  // input beats
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // point_x[17:0], point_y[35:18], sample_value[67:36], cell_x[75:68],
  // cell_y[83:76], zero pad [87:84]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // opcode: 0 splat, 1 read
  input  logic             s_axis_tuser,
  // result beats
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // weighted_sum[63:0], weight_total[103:64]
  output logic [OUT_W-1:0] m_axis_tdata
);

  ggs_cmd_t  cmd;
  ggs_stat_t stat;

  // registers are plain flops, always writable
  assign cfg_ready = 1'b1;

  ggs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ggs_datapath #(
    .GRID_W           (GRID_W),
    .GRID_H           (GRID_H),
    .MAX_REACH        (MAX_REACH),
    .WEIGHT_ROM_DEPTH (WEIGHT_ROM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/ggs_checker.sv
// port-level checks of the grid splatter, bound to the top level
// depends on ggs_pkg and gaussian_grid_splatter_assert.svh
`include "gaussian_grid_splatter_assert.svh"

module ggs_checker import ggs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result beat keeps its data
  `GGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // clearing pass follows reset
  `GGS_ASSERT_NOW(a_clear_first, $past(rst), !s_axis_tready)
  // one beat at a time
  `GGS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // no weight means nothing was added to the sum
  `GGS_ASSERT_NOW(a_zero_weight, m_axis_tvalid && (m_axis_tdata[103:64] == 40'd0),
    m_axis_tdata[63:0] == 64'd0)

endmodule

bind gaussian_grid_splatter ggs_checker u_ggs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/testbench.sv
// testbench for gaussian_grid_splatter: drives splat and read beats with random
// idling, predicts every read result with an own grid model and checks it
// depends on ggs_pkg and the gaussian_grid_splatter rtl
class splat_scoreboard;
  logic signed [63:0] sum_grid [0:65535];
  logic [39:0]        wt_grid  [0:65535];
  logic [15:0]        exp_rom  [0:255];
  logic [8:0]         width_q, height_q;
  logic [3:0]         reach_q;
  logic [15:0]        inv_cut_q;
  logic [103:0]       pending_reads [$];
  int                 mismatches;

  function void reset_state();
    logic [63:0] e;
    logic [127:0] p;
    logic [63:0] q;
    for (int i = 0; i < 65536; i++) begin
      sum_grid[i] = 0;
      wt_grid[i] = 0;
    end
    e = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      q = (e + 64'd32768) >> 16;
      exp_rom[i] = (q > 65535) ? 16'hffff : q[15:0];
      p = e * 128'd4034748382 + (128'd1 << 31);
      e = p[95:32];
    end
    width_q = 256;
    height_q = 256;
    reach_q = 10;
    inv_cut_q = 16384;
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      ggs_pkg::REG_GRID_WIDTH:  width_q = val[8:0];
      ggs_pkg::REG_GRID_HEIGHT: height_q = val[8:0];
      ggs_pkg::REG_REACH:       reach_q = val[3:0];
      default:                  inv_cut_q = val;
    endcase
  endfunction

  // an accepted input beat updates the grid or queues the read result
  function void note_beat(logic op, logic [87:0] d);
    longint px, py, val, w, h, r, cx, cy, dx, dy, at;
    logic [63:0] d2;
    logic [127:0] prod;
    logic [63:0] idx;
    logic [15:0] wt;
    logic signed [65:0] acc;
    logic [40:0] wacc;
    int x, y;
    w = (width_q > 256) ? 256 : width_q;
    h = (height_q > 256) ? 256 : height_q;
    if (op == ggs_pkg::OP_READ) begin
      x = d[75:68];
      y = d[83:76];
      if (x < w && y < h) begin
        at = y * 256 + x;
        pending_reads.push_back({wt_grid[at], sum_grid[at]});
      end else begin
        pending_reads.push_back('0);
      end
      return;
    end
    px = $signed(d[17:0]);
    py = $signed(d[35:18]);
    val = $signed(d[67:36]);
    r = (reach_q > 15) ? 15 : reach_q;
    cx = (px < 0) ? -((-px) >>> 8) : (px >>> 8);
    cy = (py < 0) ? -((-py) >>> 8) : (py >>> 8);
    for (longint xx = cx - r; xx <= cx + r; xx++)
      for (longint yy = cy - r; yy <= cy + r; yy++) begin
        if (xx < 0 || yy < 0 || xx >= w || yy >= h) continue;
        dx = px - (xx * 256 + 128);
        dy = py - (yy * 256 + 128);
        d2 = dx * dx + dy * dy;
        prod = d2 * inv_cut_q;
        idx = prod >> 28;
        wt = (idx < 256) ? exp_rom[idx] : 16'd0;
        at = yy * 256 + xx;
        acc = sum_grid[at] + val * $signed({1'b0, wt});
        if (acc > 66'sh0_7fff_ffff_ffff_ffff) sum_grid[at] = 64'h7fff_ffff_ffff_ffff;
        else if (acc < -66'sh0_8000_0000_0000_0000)
          sum_grid[at] = 64'h8000_0000_0000_0000;
        else sum_grid[at] = acc[63:0];
        wacc = wt_grid[at] + wt;
        wt_grid[at] = wacc[40] ? 40'hff_ffff_ffff : wacc[39:0];
      end
  endfunction

  function void check_result(logic [103:0] got);
    logic [103:0] want;
    if (pending_reads.size() == 0) begin
      report("result with no read waiting");
      return;
    end
    want = pending_reads.pop_front();
    if (got[63:0] !== want[63:0])
      report($sformatf("weighted_sum got %h want %h", got[63:0], want[63:0]));
    if (got[103:64] !== want[103:64])
      report($sformatf("weight_total got %h want %h", got[103:64], want[103:64]));
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endfunction
endclass

module testbench;
  import ggs_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;  // point_x, point_y, sample_value, cell_x, cell_y, pad
  logic         s_axis_tuser = 0;   // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;       // weighted_sum, weight_total

  splat_scoreboard grid_model = new();
  bit  idle_free;   // stretch with no idling on either side
  longint cycle_count;

  gaussian_grid_splatter u_dut (.*);

  initial forever #5 clk = ~clk;

  // generous limit: clearing pass plus ~520 beats at reach up to 15
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3_000_000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stall, sample at the rising edge
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= idle_free || ($urandom_range(99) >= 15);
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) grid_model.check_result(m_axis_tdata);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    grid_model.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_beat(logic op, logic [87:0] d);
    @(negedge clk);
    while (!idle_free && $urandom_range(99) < 15) @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    grid_model.note_beat(op, d);
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [87:0] pack_beat(logic [17:0] px, logic [17:0] py,
                                            logic [31:0] v, logic [7:0] cx,
                                            logic [7:0] cy);
    return {4'd0, cy, cx, v, py, px};
  endfunction

  // splats near the used area most of the time, anywhere otherwise
  task automatic random_splat();
    logic [17:0] px, py;
    logic [31:0] v;
    if ($urandom_range(9) < 8) begin
      px = 18'($urandom_range(40 * 256) - 5 * 256);
      py = 18'($urandom_range(40 * 256) - 5 * 256);
    end else begin
      px = 18'($urandom);
      py = 18'($urandom);
    end
    v = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'h7fffffff : 32'h80000000)
                                 : $urandom;
    send_beat(OP_SPLAT, pack_beat(px, py, v, 8'($urandom), 8'($urandom)));
  endtask

  task automatic random_read();
    logic [7:0] cx, cy;
    cx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(34));
    cy = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(34));
    send_beat(OP_READ, pack_beat(18'($urandom), 18'($urandom), $urandom, cx, cy));
  endtask

  // wait for every read back, then long enough for a trailing splat to finish
  task automatic settle();
    while (grid_model.pending_reads.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYC + 1000) @(posedge clk);
  endtask

  initial begin
    grid_model.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, corners, out-of-grid reads, rom overrun
    idle_free = 1;
    send_beat(OP_SPLAT, pack_beat(18'h1ffff, 18'h1ffff, 32'h7fffffff, 8'hff, 8'hff));
    send_beat(OP_SPLAT, pack_beat(18'h20000, 18'h20000, 32'h80000000, 8'h00, 8'h00));
    send_beat(OP_SPLAT, pack_beat(18'h00080, 18'h00080, 32'h7fffffff, 8'h00, 8'h00));
    send_beat(OP_SPLAT, pack_beat(18'h00080, 18'h00080, 32'h7fffffff, 8'h00, 8'h00));
    send_beat(OP_SPLAT, pack_beat(18'h3ff00, 18'h3fe80, 32'h80000000, 8'h00, 8'h00));
    send_beat(OP_SPLAT, pack_beat(18'hffff, 18'h0ff80, 32'h00010000, 8'h00, 8'h00));
    send_beat(OP_READ, pack_beat(18'h3ffff, 18'h3ffff, 32'hffffffff, 8'd0, 8'd0));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd1, 8'd0));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd255, 8'd255));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd10, 8'd10));
    settle();
    write_cfg(REG_GRID_WIDTH, 16'd1);
    write_cfg(REG_GRID_HEIGHT, 16'h1ff);
    write_cfg(REG_REACH, 16'd15);
    write_cfg(REG_INV_CUTOFF, 16'hffff);
    send_beat(OP_SPLAT, pack_beat(18'h00100, 18'h00300, 32'h00020000, 8'h00, 8'h00));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd0, 8'd3));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd1, 8'd3));
    settle();
    write_cfg(REG_GRID_WIDTH, 16'd0);
    write_cfg(REG_REACH, 16'd0);
    write_cfg(REG_INV_CUTOFF, 16'd0);
    send_beat(OP_SPLAT, pack_beat(18'h00100, 18'h00100, 32'h00030000, 8'h00, 8'h00));
    send_beat(OP_READ, pack_beat('0, '0, '0, 8'd0, 8'd0));
    settle();

    // random phases, each with its own setting
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(REG_GRID_WIDTH, (ph == 0) ? 16'd256 : 16'($urandom_range(511)));
      write_cfg(REG_GRID_HEIGHT, (ph == 0) ? 16'd256 : 16'($urandom_range(511)));
      write_cfg(REG_REACH, (ph == 1) ? 16'd15 : 16'($urandom_range(4)));
      write_cfg(REG_INV_CUTOFF, (ph == 2) ? 16'd0 : 16'($urandom));
      idle_free = (ph == 3);
      for (int k = 0; k < 50; k++)
        if ($urandom_range(1)) random_splat();
        else random_read();
      settle();
    end

    if (grid_model.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ggs_pkg.sv
hw/rtl/ggs_ctrl.sv
hw/rtl/ggs_datapath.sv
hw/rtl/gaussian_grid_splatter.sv
hw/rtl/ggs_checker.sv
tb/testbench.sv
